/* rtl/bpe_pkg.sv */
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared types and constants for the Bezier patch evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpe_pkg;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 96;
  localparam int COORD_W    = 32;
  localparam int PARAM_W    = 17;
  localparam int INDEX_W    = 2;

  localparam logic [PARAM_W-1:0] ONE_Q16 = 17'h10000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [PARAM_W-1:0]        param_t;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_EVAL = 1'b1
  } action_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    action_t             kind;
    logic [INDEX_W-1:0]  row;
    logic [INDEX_W-1:0]  col;
    point_t              pt;
    param_t              u;
    param_t              v;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/bezier_patch_evaluator.sv */
// ----------------------------------------------------------------------------
// bezier_patch_evaluator
// Bicubic-style Bezier patch point evaluation by de Casteljau, Q16.16.
//
//  channel  dir  tdata (lsb up)                                tuser
//  s_*      in   row_index[1:0] col_index[3:2] point_x[35:4]   action
//                point_y[67:36] point_z[99:68] u_param[116:100]
//                v_param[133:117], zero pad to 136
//  m_*      out  result_x[31:0] result_y[63:32] result_z[95:64] -
//
// Load beat: written to the store; the engine stays idle. Evaluate beat:
//   each lerp passes S_MUL then S_ADD on the one lerp unit per coordinate;
//   row fetch is one point per cycle off the single store read port.
// Reset: store reads as zero through per-entry valid bits, no clearing pass.
// A two-entry queue takes beats while the engine works or a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module bezier_patch_evaluator
  import bpe_pkg::*;
#(
  parameter int ROWS = 4,
  parameter int COLS = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // row_index, col_index, point_x, point_y, point_z, u_param, v_param
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // action
  input  wire logic                  s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // result_x, result_y, result_z
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  bpe_front #(.ROWS(ROWS), .COLS(COLS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  bpe_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd.kind == ACT_EVAL) |=> !cmd_ready)
    else $error("engine did not leave idle on evaluate");

  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd.kind == ACT_LOAD) && !m_tvalid |=> !m_tvalid)
    else $error("load produced a result");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!cmd_ready))
    else $error("result raised while engine idle");

endmodule

`default_nettype wire

/* rtl/bpe_front.sv */
// ----------------------------------------------------------------------------
// bpe_front
// Input side: unpacks beats, drops loads outside the grid, clamps u and v,
// and queues commands for the engine in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bpe_front
  import bpe_pkg::*;
#(
  parameter int ROWS = 4,
  parameter int COLS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [IN_DATA_W-1:0] s_tdata,
  input  wire logic                 s_tuser,
  output logic                      cmd_valid,
  input  wire logic                 cmd_ready,
  output cmd_t                      cmd
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  cmd_t       in_cmd;
  logic       in_range;
  logic       push;
  logic       pop;
  param_t     u_raw;
  param_t     v_raw;

  always_comb begin
    u_raw          = s_tdata[116:100];
    v_raw          = s_tdata[133:117];
    in_cmd.kind    = action_t'(s_tuser);
    in_cmd.row     = s_tdata[1:0];
    in_cmd.col     = s_tdata[3:2];
    in_cmd.pt.x    = s_tdata[35:4];
    in_cmd.pt.y    = s_tdata[67:36];
    in_cmd.pt.z    = s_tdata[99:68];
    in_cmd.u       = (u_raw > ONE_Q16) ? ONE_Q16 : u_raw;
    in_cmd.v       = (v_raw > ONE_Q16) ? ONE_Q16 : v_raw;
    in_range       = (int'(in_cmd.row) < ROWS) && (int'(in_cmd.col) < COLS);
  end

  assign s_tready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = s_tvalid && s_tready && ((in_cmd.kind == ACT_EVAL) || in_range);
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/bpe_lerp.sv */
// ----------------------------------------------------------------------------
// bpe_lerp
// One coordinate lerp, a + t*(b-a) rounded to nearest in Q16.16.
// Product is registered; the add stage is combinational off that register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpe_lerp
  import bpe_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   en,
  input  wire coord_t a,
  input  wire coord_t b,
  input  wire param_t t,
  output coord_t      res
);

  logic signed [32:0] diff;
  logic signed [50:0] prod;
  logic signed [50:0] prod_q;
  coord_t             a_q;
  logic signed [50:0] acc;

  assign diff = {b[31], b} - {a[31], a};
  assign prod = $signed({1'b0, t}) * diff;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_q <= prod;
      a_q    <= a;
    end
  end

  assign acc = {{3{a_q[31]}}, a_q, 16'b0} + prod_q + 51'sd32768;
  assign res = acc[47:16];

endmodule

`default_nettype wire

/* rtl/bpe_back.sv */
// ----------------------------------------------------------------------------
// bpe_back
// Engine: control point store, row fetch, de Casteljau reduction over a
// shift line with one shared lerp per coordinate, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpe_back
  import bpe_pkg::*;
#(
  parameter int ROWS = 4,
  parameter int COLS = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  output logic                       cmd_ready,
  input  wire cmd_t                  cmd,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(ROWS);
  localparam int N     = (ROWS > COLS) ? ROWS : COLS;
  localparam int LW    = $clog2(N + 1);
  localparam int IW    = $clog2(COLS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_MUL,
    S_ADD,
    S_DONE
  } state_t;

  state_t   state;
  point_t   w [N];
  point_t   w_next [N];
  point_t   rr [ROWS];
  point_t   rr_next [ROWS];
  logic [RW-1:0] row_cnt;
  logic [IW-1:0] iss;
  logic [IW-1:0] rcv;
  logic          rd_pend;
  logic [LW-1:0] len;
  logic [LW-1:0] k;
  logic          vert;
  param_t        u_q;
  param_t        v_q;
  point_t        out_pt;

  // store
  coord_t        mem_x [DEPTH];
  coord_t        mem_y [DEPTH];
  coord_t        mem_z [DEPTH];
  logic [DEPTH-1:0] vld;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  point_t        rd_q;
  logic          rd_vld_q;
  point_t        rd_pt;

  // reduction datapath
  param_t        t_sel;
  logic          mul_en;
  point_t        lerp_res;
  logic          last_lerp;
  logic          level_done;
  logic          last_row;
  logic          shift1;
  logic          shift2;
  logic          ins_en;
  logic [LW-1:0] ins_pos;
  point_t        ins_val;

  assign cmd_ready = (state == S_IDLE);
  assign wr_en     = cmd_valid && cmd_ready && (cmd.kind == ACT_LOAD);
  assign wr_addr   = AW'(int'(cmd.row) * COLS + int'(cmd.col));
  assign rd_en     = (state == S_FETCH) && (int'(iss) < COLS);
  assign rd_addr   = AW'(int'(row_cnt) * COLS + int'(iss));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= cmd.pt.x;
      mem_y[wr_addr] <= cmd.pt.y;
      mem_z[wr_addr] <= cmd.pt.z;
    end
    if (rd_en) begin
      rd_q.x <= mem_x[rd_addr];
      rd_q.y <= mem_y[rd_addr];
      rd_q.z <= mem_z[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= vld[rd_addr];
      end
    end
  end

  // never-written entries read as zero
  assign rd_pt = rd_vld_q ? rd_q : '0;

  assign t_sel  = vert ? v_q : u_q;
  assign mul_en = (state == S_MUL);

  bpe_lerp u_lerp_x (.clk(clk), .en(mul_en), .a(w[0].x), .b(w[1].x), .t(t_sel),
                     .res(lerp_res.x));
  bpe_lerp u_lerp_y (.clk(clk), .en(mul_en), .a(w[0].y), .b(w[1].y), .t(t_sel),
                     .res(lerp_res.y));
  bpe_lerp u_lerp_z (.clk(clk), .en(mul_en), .a(w[0].z), .b(w[1].z), .t(t_sel),
                     .res(lerp_res.z));

  assign last_lerp  = (k == len - LW'(2));
  assign level_done = (state == S_ADD) && last_lerp && (len == LW'(2));
  assign last_row   = (row_cnt == RW'(ROWS - 1));

  always_comb begin
    shift1  = 1'b0;
    shift2  = 1'b0;
    ins_en  = 1'b0;
    ins_pos = '0;
    ins_val = lerp_res;
    case (state)
      S_FETCH: begin
        shift1  = rd_pend;
        ins_en  = rd_pend;
        ins_pos = LW'(COLS - 1);
        ins_val = rd_pt;
      end
      S_ADD: begin
        ins_en = 1'b1;
        if (last_lerp) begin
          // drop the leftover point of the level as well
          shift2  = 1'b1;
          ins_pos = len - LW'(2);
        end else begin
          shift1  = 1'b1;
          ins_pos = len - LW'(1);
        end
      end
      default: begin
        shift1 = 1'b0;
      end
    endcase

    for (int j = 0; j < N; j++) begin
      w_next[j] = w[j];
      if (ins_en && (int'(ins_pos) == j)) begin
        w_next[j] = ins_val;
      end else if (shift2 && (j + 2 < N)) begin
        w_next[j] = w[j + 2];
      end else if (shift1 && (j + 1 < N)) begin
        w_next[j] = w[j + 1];
      end
    end

    for (int j = 0; j < ROWS; j++) begin
      rr_next[j] = rr[j];
    end
    if (level_done && !vert) begin
      for (int j = 0; j < ROWS - 1; j++) begin
        rr_next[j] = rr[j + 1];
      end
      rr_next[ROWS-1] = lerp_res;
      if (last_row) begin
        for (int j = 0; j < ROWS; j++) begin
          w_next[j] = rr_next[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < N; j++) begin
      w[j] <= w_next[j];
    end
    for (int j = 0; j < ROWS; j++) begin
      rr[j] <= rr_next[j];
    end
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      rd_pend  <= 1'b0;
      row_cnt  <= '0;
      iss      <= '0;
      rcv      <= '0;
      len      <= '0;
      k        <= '0;
      vert     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid && (cmd.kind == ACT_EVAL)) begin
            u_q     <= cmd.u;
            v_q     <= cmd.v;
            row_cnt <= '0;
            iss     <= '0;
            rcv     <= '0;
            rd_pend <= 1'b0;
            vert    <= 1'b0;
            state   <= S_FETCH;
          end
        end
        S_FETCH: begin
          rd_pend <= rd_en;
          if (rd_en) begin
            iss <= iss + IW'(1);
          end
          if (rd_pend) begin
            rcv <= rcv + IW'(1);
            if (rcv == IW'(COLS - 1)) begin
              len   <= LW'(COLS);
              k     <= '0;
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          state <= S_ADD;
        end
        S_ADD: begin
          if (level_done && vert) begin
            k     <= '0;
            state <= S_DONE;
          end else if (level_done && last_row) begin
            vert  <= 1'b1;
            len   <= LW'(ROWS);
            k     <= '0;
            state <= S_MUL;
          end else if (level_done) begin
            row_cnt <= row_cnt + RW'(1);
            iss     <= '0;
            rcv     <= '0;
            rd_pend <= 1'b0;
            k       <= '0;
            state   <= S_FETCH;
          end else begin
            if (last_lerp) begin
              len <= len - LW'(1);
              k   <= '0;
            end else begin
              k <= k + LW'(1);
            end
            state <= S_MUL;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            out_pt   <= w[0];
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {out_pt.z, out_pt.y, out_pt.x};

endmodule

`default_nettype wire
